@@ hdl/rcdb_pkg.sv @@
// Shared constants, types and arithmetic helpers of the contact Delassus block unit.
package rcdb_pkg;

   localparam int MAX_CONTACTS       = 16;
   localparam int MAX_WORLD_CONTACTS = 256;
   localparam int NUM_WORDS          = 28;
   localparam int CNT_W              = $clog2(MAX_CONTACTS + 1);
   localparam int SLOT_W             = $clog2(MAX_CONTACTS);
   localparam int ADDR_W             = 7;

   // Word memory map: body words, contact points, then scratch vectors and matrices.
   localparam logic [ADDR_W-1:0] W_INVMASS  = 7'd0;
   localparam logic [ADDR_W-1:0] W_IINV     = 7'd1;
   localparam logic [ADDR_W-1:0] W_INERT    = 7'd10;
   localparam logic [ADDR_W-1:0] W_OMEGA    = 7'd19;
   localparam logic [ADDR_W-1:0] W_VEL      = 7'd22;
   localparam logic [ADDR_W-1:0] W_POS      = 7'd25;
   localparam logic [ADDR_W-1:0] POINT_BASE = 7'd28;
   localparam logic [ADDR_W-1:0] RI_BASE    = 7'd76;
   localparam logic [ADDR_W-1:0] RJ_BASE    = 7'd79;
   localparam logic [ADDR_W-1:0] A_BASE     = 7'd82;
   localparam logic [ADDR_W-1:0] U_BASE     = 7'd91;
   localparam logic [ADDR_W-1:0] T_BASE     = 7'd94;
   localparam logic [ADDR_W-1:0] H_BASE     = 7'd97;
   localparam int                MEM_DEPTH  = 100;

   localparam logic [16:0] DT_RESET = 17'd1092;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_APPEND  = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR   = 2'd3;

   localparam logic [1:0] KIND_MAT = 2'd0;
   localparam logic [1:0] KIND_VEC = 2'd1;
   localparam logic [1:0] KIND_SKW = 2'd2;

   localparam logic [2:0] MODE_WRITE = 3'd0;
   localparam logic [2:0] MODE_DT    = 3'd1;
   localparam logic [2:0] MODE_BLK   = 3'd2;
   localparam logic [2:0] MODE_CREG  = 3'd3;
   localparam logic [2:0] MODE_RES   = 3'd4;

   localparam logic [3:0] JOB_RI = 4'd0;
   localparam logic [3:0] JOB_A  = 4'd1;
   localparam logic [3:0] JOB_RJ = 4'd2;
   localparam logic [3:0] JOB_B  = 4'd3;
   localparam logic [3:0] JOB_U  = 4'd4;
   localparam logic [3:0] JOB_Q  = 4'd5;
   localparam logic [3:0] JOB_H  = 4'd6;
   localparam logic [3:0] JOB_C  = 4'd7;
   localparam logic [3:0] JOB_S  = 4'd8;

   typedef struct packed {
      logic [1:0]        xk;
      logic [ADDR_W-1:0] xb;
      logic [1:0]        yk;
      logic [ADDR_W-1:0] yb;
      logic              is_vec;
      logic [2:0]        mode;
      logic [ADDR_W-1:0] db;
   } job_desc_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic              neg;
      logic              zero;
   } elem_ref_type;

   function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
      logic signed [31:0] r;
      if (v > 67'sd2147483647) r = 32'sh7fffffff;
      else if (v < -67'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] x);
      logic signed [31:0] r;
      if (x == 32'sh80000000) r = 32'sh7fffffff;
      else r = -x;
      return r;
   endfunction

   function automatic logic signed [31:0] xform(input logic signed [31:0] x,
                                                input elem_ref_type e);
      logic signed [31:0] r;
      if (e.zero) r = 32'sd0;
      else if (e.neg) r = neg_sat(x);
      else r = x;
      return r;
   endfunction

   // Element (row, col) of skew(v) with v stored at base.
   function automatic elem_ref_type skew_ref(input logic [ADDR_W-1:0] base,
                                             input logic [1:0] row, input logic [1:0] col);
      elem_ref_type e;
      e.addr = base;
      e.neg  = 1'b0;
      e.zero = 1'b0;
      unique case ({row, col})
         4'b0001: begin e.addr = base + 7'd2; e.neg = 1'b1; end
         4'b0010: begin e.addr = base + 7'd1; end
         4'b0100: begin e.addr = base + 7'd2; end
         4'b0110: begin e.addr = base;        e.neg = 1'b1; end
         4'b1000: begin e.addr = base + 7'd1; e.neg = 1'b1; end
         4'b1001: begin e.addr = base;        end
         default: begin e.zero = 1'b1; end
      endcase
      return e;
   endfunction

   function automatic elem_ref_type elem_ref(input logic [1:0] kind,
                                             input logic [ADDR_W-1:0] base,
                                             input logic [1:0] row, input logic [1:0] col);
      elem_ref_type e;
      e.addr = base;
      e.neg  = 1'b0;
      e.zero = 1'b0;
      unique case (kind)
         KIND_MAT: e.addr = base + {5'b0, row} * 7'd3 + {5'b0, col};
         KIND_VEC: e.addr = base + {5'b0, row};
         KIND_SKW: e = skew_ref(base, row, col);
         default:  e.zero = 1'b1;
      endcase
      return e;
   endfunction

   function automatic job_desc_type job_desc(input logic [3:0] job);
      job_desc_type d;
      d = '0;
      unique case (job)
         JOB_A: d = '{KIND_SKW, RI_BASE, KIND_MAT, W_IINV,  1'b0, MODE_WRITE, A_BASE};
         JOB_B: d = '{KIND_MAT, A_BASE,  KIND_SKW, RJ_BASE, 1'b0, MODE_BLK,   A_BASE};
         JOB_U: d = '{KIND_MAT, W_IINV,  KIND_VEC, W_OMEGA, 1'b1, MODE_WRITE, U_BASE};
         JOB_Q: d = '{KIND_SKW, RI_BASE, KIND_VEC, U_BASE,  1'b1, MODE_DT,    T_BASE};
         JOB_H: d = '{KIND_MAT, W_INERT, KIND_VEC, W_OMEGA, 1'b1, MODE_WRITE, H_BASE};
         JOB_C: d = '{KIND_SKW, T_BASE,  KIND_VEC, H_BASE,  1'b1, MODE_CREG,  H_BASE};
         JOB_S: d = '{KIND_SKW, RI_BASE, KIND_VEC, W_OMEGA, 1'b1, MODE_RES,   H_BASE};
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

@@ hdl/rigid_contact_delassus_blocks_unit.sv @@
// Contact Delassus block unit: word memory, shared multiply-accumulate and job sequencer.
//
// Usage: the req_ channel carries one command word per accept: load a body word,
// append a contact point, clear the contact list, or compute the Delassus blocks of
// one contact slot. Load, append and clear give no result; append keeps req_stall
// high while it writes the y and z words, load and clear do not stall. A compute of
// slot i walks all N stored contacts and gives 3*N block rows, then one residual
// row flagged last. Every matrix element is a 3-term dot product run on one shared
// 33x32 multiplier fed from a word memory with one read and one write port. The
// sequencer works on one command at a time; req_stall is high while it runs.
// Results leave through an output register; while the receiver stalls rsp_, the
// sequencer holds at the row that would overwrite it.
// The csr_ port holds time_step at byte address 0 (pready always high).
// Reset (synchronous) empties the contact list, sets time_step to its default and
// idles the sequencer; body words and points are undefined until written.
module rigid_contact_delassus_blocks_unit import rcdb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [4:0]         req_index,
   input  logic [7:0]         req_contact_id,
   input  logic               req_is_body0,
   input  logic signed [31:0] req_value_x,
   input  logic signed [31:0] req_value_y,
   input  logic signed [31:0] req_value_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_row_index,
   output logic [7:0]         rsp_col_contact,
   output logic               rsp_is_residual,
   output logic signed [31:0] rsp_elem0,
   output logic signed [31:0] rsp_elem1,
   output logic signed [31:0] rsp_elem2,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_APPEND = 2'd1;
   localparam logic [1:0] ST_VSUB   = 2'd2;
   localparam logic [1:0] ST_DOT    = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [3:0]        job_ff, job_in;
   logic [3:0]        f_ff, f_in;
   logic [1:0]        r_ff, r_in, c_ff, c_in;
   logic [SLOT_W-1:0] j_ff, j_in, slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [16:0]       dt_ff;

   logic signed [31:0] invmass_ff, hold_y_ff, hold_z_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] cres_ff [3];
   logic signed [31:0] row_ff [3];
   logic [7:0]         cid_i_ff;

   logic [31:0]        mem [MEM_DEPTH];
   logic signed [31:0] mem_rdata_ff;
   logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
   logic               mem_we;
   logic [31:0]        mem_wdata;

   logic [8:0]         idmem [MAX_CONTACTS];
   logic [8:0]         id_q_ff;
   logic [SLOT_W-1:0]  id_raddr;

   logic signed [31:0] opa_ff;
   logic signed [64:0] prod_ff;
   logic signed [66:0] acc_ff;
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [64:0] mul_p;

   logic               rsp_valid_ff;
   logic [9:0]         rsp_row_ff;
   logic [7:0]         rsp_col_ff;
   logic               rsp_res_ff, rsp_last_ff;
   logic signed [31:0] rsp_e0_ff, rsp_e1_ff, rsp_e2_ff;

   job_desc_type       jd;
   elem_ref_type       xref_i, yref_i, xref_r, yref_r;
   logic [3:0]         step;
   logic signed [31:0] xval, yval, dres, fin, pre_blk, res_val, blk_val, pv, emit_e2;
   logic               accept, out_free, needs_mul, at_fin, emit_now, hold, done_el, last_el;
   logic [ADDR_W-1:0]  pt_base, vdst, dst_addr;
   logic [1:0]         vk;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign jd     = job_desc(job_ff);
   assign step   = f_ff - 4'd1;
   assign xref_i = elem_ref(jd.xk, jd.xb, r_ff, f_ff[2:1]);
   assign yref_i = elem_ref(jd.yk, jd.yb, f_ff[2:1], c_ff);
   assign xref_r = elem_ref(jd.xk, jd.xb, r_ff, step[2:1]);
   assign yref_r = elem_ref(jd.yk, jd.yb, step[2:1], c_ff);
   assign xval   = xform(mem_rdata_ff, xref_r);
   assign yval   = xform(mem_rdata_ff, yref_r);

   assign dres    = sat32(acc_ff >>> 16);
   assign fin     = sat32(67'(prod_ff) >>> 16);
   assign pre_blk = sat32(((r_ff == c_ff) ? 67'(invmass_ff) : 67'sd0) - 67'(dres));
   assign res_val = sat32(67'(vel_ff[r_ff]) - 67'(dres) + 67'(cres_ff[r_ff]));
   assign blk_val = id_q_ff[8] ? fin : neg_sat(fin);
   assign pv      = (jd.mode == MODE_BLK) ? pre_blk : dres;
   assign emit_e2 = (jd.mode == MODE_BLK) ? blk_val : res_val;

   assign needs_mul = (jd.mode == MODE_BLK) || (jd.mode == MODE_DT);
   assign at_fin    = (state_ff == ST_DOT) && (f_ff == (needs_mul ? 4'd9 : 4'd8));
   assign emit_now  = at_fin && (((jd.mode == MODE_BLK) && (c_ff == 2'd2)) ||
                                 ((jd.mode == MODE_RES) && (r_ff == 2'd2)));
   assign hold      = emit_now && !out_free;
   assign done_el   = at_fin && !hold;
   assign last_el   = jd.is_vec ? (r_ff == 2'd2) : ((r_ff == 2'd2) && (c_ff == 2'd2));
   assign dst_addr  = jd.db + (jd.is_vec ? {5'b0, r_ff} : ({5'b0, r_ff} * 7'd3 + {5'b0, c_ff}));

   assign pt_base = POINT_BASE + ADDR_W'(((job_ff == JOB_RI) ? slot_ff : j_ff)) * 7'd3;
   assign vdst    = (job_ff == JOB_RI) ? RI_BASE : RJ_BASE;
   assign vk      = 2'(f_ff - 4'd1);

   // Shared multiplier: dot terms, then the dt scaling at the end of an element.
   always_comb begin
      if ((state_ff == ST_DOT) && (f_ff == 4'd8)) begin
         mul_a = {16'b0, dt_ff};
         mul_b = pv;
      end else begin
         mul_a = 33'(opa_ff);
         mul_b = yval;
      end
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      mem_raddr = pt_base + {5'b0, f_ff[1:0]};
      if (state_ff == ST_DOT) mem_raddr = f_ff[0] ? yref_i.addr : xref_i.addr;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = dst_addr;
      mem_wdata = dres;
      priority case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_LOAD) && (req_index < 5'(NUM_WORDS))) begin
               mem_we    = 1'b1;
               mem_waddr = 7'(req_index);
               mem_wdata = req_value_x;
            end else if (accept && (req_func == FUNC_APPEND)) begin
               mem_we    = (count_ff < CNT_W'(MAX_CONTACTS)) &&
                           ({1'b0, req_contact_id} < 9'(MAX_WORLD_CONTACTS));
               mem_waddr = POINT_BASE + ADDR_W'(count_ff[SLOT_W-1:0]) * 7'd3;
               mem_wdata = req_value_x;
            end
         end
         ST_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = POINT_BASE + ADDR_W'(count_ff[SLOT_W-1:0]) * 7'd3 +
                        {6'b0, 1'b1} + {6'b0, f_ff[0]};
            mem_wdata = f_ff[0] ? hold_z_ff : hold_y_ff;
         end
         ST_VSUB: begin
            mem_we    = (f_ff != 4'd0);
            mem_waddr = vdst + {5'b0, vk};
            mem_wdata = sat32(67'(mem_rdata_ff) - 67'(pos_ff[vk]));
         end
         ST_DOT: begin
            mem_we    = at_fin && ((jd.mode == MODE_WRITE) || (jd.mode == MODE_DT));
            mem_wdata = (jd.mode == MODE_DT) ? fin : dres;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   assign id_raddr = (job_ff == JOB_RI) ? slot_ff : j_ff;
   always_ff @(posedge clock) begin
      if (accept && (req_func == FUNC_APPEND) && (count_ff < CNT_W'(MAX_CONTACTS)))
         idmem[count_ff[SLOT_W-1:0]] <= {req_is_body0, req_contact_id};
      id_q_ff <= idmem[id_raddr];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      f_in     = f_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      j_in     = j_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_APPEND: begin
                     if ((count_ff < CNT_W'(MAX_CONTACTS)) &&
                         ({1'b0, req_contact_id} < 9'(MAX_WORLD_CONTACTS))) begin
                        state_in = ST_APPEND;
                        f_in     = 4'd0;
                     end
                  end
                  FUNC_COMPUTE: begin
                     if (CNT_W'(req_index) < count_ff && {1'b0, req_index} < 6'(MAX_CONTACTS)) begin
                        state_in = ST_VSUB;
                        job_in   = JOB_RI;
                        slot_in  = req_index[SLOT_W-1:0];
                        f_in     = 4'd0;
                     end
                  end
                  FUNC_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         ST_APPEND: begin
            f_in = f_ff + 4'd1;
            if (f_ff[0]) begin
               count_in = count_ff + CNT_W'(1);
               state_in = ST_IDLE;
            end
         end
         ST_VSUB: begin
            f_in = f_ff + 4'd1;
            if (f_ff == 4'd3) begin
               state_in = ST_DOT;
               job_in   = (job_ff == JOB_RI) ? JOB_A : JOB_B;
               f_in     = 4'd0;
               r_in     = 2'd0;
               c_in     = 2'd0;
            end
         end
         ST_DOT: begin
            if (!at_fin) begin
               f_in = f_ff + 4'd1;
            end else if (done_el) begin
               f_in = 4'd0;
               if (!last_el) begin
                  if (jd.is_vec || (c_ff == 2'd2)) begin
                     r_in = r_ff + 2'd1;
                     c_in = 2'd0;
                  end else begin
                     c_in = c_ff + 2'd1;
                  end
               end else begin
                  r_in = 2'd0;
                  c_in = 2'd0;
                  unique case (job_ff)
                     JOB_A: begin
                        state_in = ST_VSUB;
                        job_in   = JOB_RJ;
                        j_in     = '0;
                     end
                     JOB_B: begin
                        if ({1'b0, j_ff} + CNT_W'(1) < count_ff) begin
                           state_in = ST_VSUB;
                           job_in   = JOB_RJ;
                           j_in     = j_ff + SLOT_W'(1);
                        end else begin
                           job_in = JOB_U;
                        end
                     end
                     JOB_U: job_in = JOB_Q;
                     JOB_Q: job_in = JOB_H;
                     JOB_H: job_in = JOB_C;
                     JOB_C: job_in = JOB_S;
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff   <= JOB_RI;
         f_ff     <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         j_ff     <= '0;
         slot_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         f_ff     <= f_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         j_ff     <= j_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept && (req_func == FUNC_LOAD)) begin
         if (req_index == 5'(W_INVMASS)) invmass_ff <= req_value_x;
         for (int k = 0; k < 3; k++) begin
            if (req_index == 5'(W_VEL) + 5'(k)) vel_ff[k] <= req_value_x;
            if (req_index == 5'(W_POS) + 5'(k)) pos_ff[k] <= req_value_x;
         end
      end
      if (accept) begin
         hold_y_ff <= req_value_y;
         hold_z_ff <= req_value_z;
      end
      if ((state_ff == ST_VSUB) && (job_ff == JOB_RI) && (f_ff == 4'd3))
         cid_i_ff <= id_q_ff[7:0];
      if (state_ff == ST_DOT) begin
         // odd f 1..5 takes the x operand, even f 2..6 multiplies by the y operand
         if ((f_ff == 4'd1) || (f_ff == 4'd3) || (f_ff == 4'd5)) opa_ff <= xval;
         if ((f_ff == 4'd2) || (f_ff == 4'd4) || (f_ff == 4'd6) ||
             ((f_ff == 4'd8) && needs_mul)) prod_ff <= mul_p;
         if (f_ff == 4'd0) acc_ff <= '0;
         else if ((f_ff == 4'd3) || (f_ff == 4'd5) || (f_ff == 4'd7))
            acc_ff <= acc_ff + 67'(prod_ff);
         if (at_fin && (jd.mode == MODE_CREG)) cres_ff[r_ff] <= dres;
         if (at_fin && (jd.mode == MODE_BLK))  row_ff[c_ff] <= blk_val;
         if (at_fin && (jd.mode == MODE_RES))  row_ff[r_ff] <= res_val;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_now && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_now && out_free) begin
         rsp_row_ff  <= 10'(cid_i_ff) * 10'd3 +
                        ((jd.mode == MODE_BLK) ? 10'(r_ff) : 10'd0);
         rsp_col_ff  <= (jd.mode == MODE_BLK) ? id_q_ff[7:0] : cid_i_ff;
         rsp_res_ff  <= (jd.mode == MODE_RES);
         rsp_last_ff <= (jd.mode == MODE_RES);
         rsp_e0_ff   <= row_ff[0];
         rsp_e1_ff   <= row_ff[1];
         rsp_e2_ff   <= emit_e2;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_index   = rsp_row_ff;
   assign rsp_col_contact = rsp_col_ff;
   assign rsp_is_residual = rsp_res_ff;
   assign rsp_elem0       = rsp_e0_ff;
   assign rsp_elem1       = rsp_e1_ff;
   assign rsp_elem2       = rsp_e2_ff;
   assign rsp_last        = rsp_last_ff;

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= DT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
         dt_ff <= csr_pwdata[16:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {15'd0, dt_ff};

   a_count_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOT) |=> $stable(count_ff))
      else $error("contact count changed during a compute");

   a_j_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DOT) && (job_ff == JOB_B)) |-> ({1'b0, j_ff} < count_ff))
      else $error("column slot beyond contact count");

   a_f_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOT) |-> (f_ff <= 4'd9))
      else $error("dot step counter overrun");

   a_last_residual: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_res_ff)
      else $error("last word is not the residual row");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && emit_now) |=> $stable(rsp_row_ff))
      else $error("stalled word overwritten");

endmodule

@@ test/rigid_contact_delassus_blocks_unit_tb.sv @@
// Self-checking testbench for the contact Delassus block unit.
module rigid_contact_delassus_blocks_unit_tb import rcdb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CSR_TIME_STEP = 3'd0;
   localparam logic [2:0] CSR_UNMAPPED  = 3'd4;
   localparam int         SETTLE        = 2000;

   typedef int m9_type [9];
   typedef int v3_type [3];

   typedef struct {
      logic [1:0]  func;
      logic [4:0]  idx;
      logic [7:0]  cid;
      logic        b0;
      int          x, y, z;
   } cmd_type;

   typedef struct {
      logic [9:0] row;
      logic [7:0] col;
      logic       res;
      int         e0, e1, e2;
      logic       last;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = '0;
   logic [4:0] req_index = '0;
   logic [7:0] req_contact_id = '0;
   logic req_is_body0 = 1'b0;
   logic signed [31:0] req_value_x = '0, req_value_y = '0, req_value_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [9:0] rsp_row_index;
   logic [7:0] rsp_col_contact;
   logic rsp_is_residual, rsp_last;
   logic signed [31:0] rsp_elem0, rsp_elem1, rsp_elem2;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   rigid_contact_delassus_blocks_unit DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // body mirror
   int         body[28];
   int         pts[48];
   logic [7:0] ids[16];
   logic       side[16];
   int         ncont = 0;
   logic [16:0] step_dt = DT_RESET;

   cmd_type pend_q[$];
   row_type blocks_q[$];
   cmd_type cur;
   int   errors = 0;
   bit   calm = 0, hold_go = 0, hold_done = 0;
   int   hold_cnt = 0;

   function automatic int sat(input logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'sh7fffffff;
      if (v < -96'sd2147483648) return 32'sh80000000;
      return int'(v[31:0]);
   endfunction

   function automatic int dot(input int a0, a1, a2, b0, b1, b2);
      logic signed [95:0] acc;
      acc = 96'(longint'(a0) * longint'(b0)) + 96'(longint'(a1) * longint'(b1))
          + 96'(longint'(a2) * longint'(b2));
      return sat(acc >>> 16);
   endfunction

   function automatic int scale_dt(input int x);
      longint p;
      p = longint'({15'b0, step_dt}) * longint'(x);
      return sat(96'(p >>> 16));
   endfunction

   task automatic mul_mm(input m9_type a, input m9_type b, output m9_type o);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            o[r*3+c] = dot(a[r*3], a[r*3+1], a[r*3+2], b[c], b[3+c], b[6+c]);
   endtask

   task automatic mul_mv(input m9_type a, input v3_type v, output v3_type o);
      for (int r = 0; r < 3; r++)
         o[r] = dot(a[r*3], a[r*3+1], a[r*3+2], v[0], v[1], v[2]);
   endtask

   task automatic to_skew(input v3_type v, output m9_type s);
      s = '{0, sat(-96'(v[2])), v[1], v[2], 0, sat(-96'(v[0])), sat(-96'(v[1])), v[0], 0};
   endtask

   task automatic lever_skew(input int slot, output m9_type s);
      v3_type r;
      for (int k = 0; k < 3; k++) r[k] = sat(96'(pts[slot*3+k]) - 96'(body[25+k]));
      to_skew(r, s);
   endtask

   task automatic apply_cmd(input cmd_type c);
      m9_type si, sj, a, b, iinv, inert, tk;
      v3_type w, v, u, q, t, h, cv, s;
      row_type o;
      int e;
      if (c.func == FUNC_LOAD) begin
         if (c.idx < 28) body[c.idx] = c.x;
      end else if (c.func == FUNC_APPEND) begin
         if (ncont < MAX_CONTACTS) begin
            pts[ncont*3] = c.x; pts[ncont*3+1] = c.y; pts[ncont*3+2] = c.z;
            ids[ncont] = c.cid; side[ncont] = c.b0;
            ncont++;
         end
      end else if (c.func == FUNC_CLEAR) begin
         ncont = 0;
      end else if (c.idx < ncont) begin
         for (int k = 0; k < 9; k++) begin
            iinv[k] = body[1+k]; inert[k] = body[10+k];
         end
         for (int k = 0; k < 3; k++) begin
            w[k] = body[19+k]; v[k] = body[22+k];
         end
         lever_skew(c.idx, si);
         mul_mm(si, iinv, a);
         for (int j = 0; j < ncont; j++) begin
            lever_skew(j, sj);
            mul_mm(a, sj, b);
            for (int r = 0; r < 3; r++) begin
               int m[3];
               for (int cc = 0; cc < 3; cc++) begin
                  e = scale_dt(sat(96'((r == cc) ? body[0] : 0) - 96'(b[r*3+cc])));
                  m[cc] = side[j] ? e : sat(-96'(e));
               end
               o = '{10'(3 * ids[c.idx] + r), ids[j], 1'b0, m[0], m[1], m[2], 1'b0};
               blocks_q = {blocks_q, o};
            end
         end
         mul_mv(iinv, w, u);
         mul_mv(si, u, q);
         for (int k = 0; k < 3; k++) t[k] = scale_dt(q[k]);
         to_skew(t, tk);
         mul_mv(inert, w, h);
         mul_mv(tk, h, cv);
         mul_mv(si, w, s);
         o = '{10'(3 * ids[c.idx]), ids[c.idx], 1'b1,
               sat(96'(v[0]) - 96'(s[0]) + 96'(cv[0])),
               sat(96'(v[1]) - 96'(s[1]) + 96'(cv[1])),
               sat(96'(v[2]) - 96'(s[2]) + 96'(cv[2])), 1'b1};
         blocks_q = {blocks_q, o};
      end
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_cmd(cur);
         if (!req_valid || !req_stall) begin
            if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
               cur = pend_q.pop_front();
               req_valid      <= 1'b1;
               req_func       <= cur.func;
               req_index      <= cur.idx;
               req_contact_id <= cur.cid;
               req_is_body0   <= cur.b0;
               req_value_x    <= cur.x;
               req_value_y    <= cur.y;
               req_value_z    <= cur.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (blocks_q.size() == 0) begin
               $display("%0t: unexpected word row %0d col %0d", $time, rsp_row_index,
                        rsp_col_contact);
               errors++;
            end else begin
               row_type x;
               x = blocks_q.pop_front();
               if (rsp_row_index !== x.row || rsp_col_contact !== x.col ||
                   rsp_is_residual !== x.res || rsp_elem0 !== x.e0 ||
                   rsp_elem1 !== x.e1 || rsp_elem2 !== x.e2 || rsp_last !== x.last) begin
                  $display("%0t: mismatch expected row %0d col %0d res %0b %h %h %h last %0b",
                           $time, x.row, x.col, x.res, x.e0, x.e1, x.e2, x.last);
                  $display("%0t:          actual row %0d col %0d res %0b %h %h %h last %0b",
                           $time, rsp_row_index, rsp_col_contact, rsp_is_residual,
                           rsp_elem0, rsp_elem1, rsp_elem2, rsp_last);
                  errors++;
               end
            end
         end
         if (hold_go && !hold_done) begin
            // long back-pressure so the block fills and stalls its input
            hold_cnt++;
            if (hold_cnt >= 3000) hold_done = 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 28;
         end
      end
   end

   int gcnt = 0;
   int issued = 0;

   function automatic int val();
      if ($urandom_range(99) < 85) return int'($urandom_range(6 * 65536)) - 3 * 65536;
      return int'($urandom);
   endfunction

   function automatic void put_cmd(input int f, input int idx, input int cid,
                                   input int b0, input int x, input int y, input int z);
      cmd_type c;
      c = '{2'(f), 5'(idx), 8'(cid), 1'(b0), x, y, z};
      pend_q = {pend_q, c};
      issued++;
      if (c.func == FUNC_APPEND && gcnt < MAX_CONTACTS) gcnt++;
      if (c.func == FUNC_CLEAR) gcnt = 0;
   endfunction

   task automatic drain();
      while (pend_q.size() != 0 || req_valid || blocks_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == CSR_TIME_STEP) step_dt = data[16:0];
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
      // read back
      csr_psel <= 1'b1; csr_paddr <= CSR_TIME_STEP;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[16:0] !== step_dt) begin
         $display("%0t: time_step read expected %h actual %h", $time, step_dt,
                  csr_prdata[16:0]);
         errors++;
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      int stop;
      stop = issued + n;
      while (issued < stop) begin
         if ($urandom_range(99) < 10)
            repeat ($urandom_range(1, 4))
               put_cmd(FUNC_LOAD, $urandom_range(27), 0, 0, val(), val(), val());
         put_cmd(FUNC_CLEAR, $urandom_range(31), $urandom, $urandom, $urandom, $urandom,
                 $urandom);
         repeat ($urandom_range(9) == 0 ? 17 : $urandom_range(1, 4))
            put_cmd(FUNC_APPEND, $urandom_range(31), $urandom_range(255), $urandom_range(1),
                    val(), val(), val());
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(9) == 0)
               put_cmd(FUNC_COMPUTE, $urandom_range(31), $urandom, $urandom, $urandom,
                       $urandom, $urandom);
            else
               put_cmd(FUNC_COMPUTE, $urandom_range(gcnt - 1), $urandom, $urandom, val(),
                       val(), val());
         end
         if ($urandom_range(19) == 0)
            put_cmd($urandom_range(3), $urandom_range(31), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < 28; k++) put_cmd(FUNC_LOAD, k, 0, 0, val(), 0, 0);
      // directed part
      put_cmd(FUNC_LOAD, 29, 0, 0, 32'h7fffffff, 0, 0);
      put_cmd(FUNC_APPEND, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      put_cmd(FUNC_APPEND, 0, 255, 1, 32'h80000000, 32'h80000000, 32'h80000000);
      put_cmd(FUNC_APPEND, 0, 17, 1, 65536, -65536, 0);
      put_cmd(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0);
      put_cmd(FUNC_COMPUTE, 1, 0, 0, 0, 0, 0);
      put_cmd(FUNC_COMPUTE, 2, 0, 0, 0, 0, 0);
      put_cmd(FUNC_COMPUTE, 5, 0, 0, 0, 0, 0);
      put_cmd(FUNC_COMPUTE, 31, 255, 1, -1, -1, -1);
      put_cmd(FUNC_LOAD, 0, 0, 0, 32'h7fffffff, 0, 0);
      put_cmd(FUNC_LOAD, 19, 0, 0, 32'h80000000, 0, 0);
      put_cmd(FUNC_COMPUTE, 1, 0, 0, 0, 0, 0);
      put_cmd(FUNC_LOAD, 0, 0, 0, 65536, 0, 0);
      put_cmd(FUNC_LOAD, 19, 0, 0, 32768, 0, 0);
      put_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
      put_cmd(FUNC_COMPUTE, 0, 0, 0, 0, 0, 0);
      drain();
      csr_write(CSR_TIME_STEP, 32'd0);
      random_phase(20);
      drain();
      csr_write(CSR_TIME_STEP, 32'd65536);
      calm = 1;
      random_phase(20);
      drain();
      calm = 0;
      csr_write(CSR_TIME_STEP, 32'h1ffff);
      csr_write(CSR_UNMAPPED, $urandom);
      random_phase(20);
      hold_go = 1;
      drain();
      csr_write(CSR_TIME_STEP, $urandom_range(65536));
      random_phase(20);
      drain();
      csr_write(CSR_TIME_STEP, {15'h7fff, 17'd1092});
      random_phase(20);
      drain();
      if (errors == 0 && blocks_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("simulation failed");
      $finish;
   end

endmodule
